### rtl/lprt_pkg.sv
package lprt_pkg;

   // Table size used when the top level is not overridden
   localparam int DEFAULT_TABLE_DEPTH = 32;

   // Multicast lookup gives at most this many results per command
   localparam int MAX_RESULTS = 32;
   localparam int MC_CNT_W    = $clog2(MAX_RESULTS);

   // Config register width and its reset value
   localparam int          NUM_IF_W     = 5;
   localparam logic [4:0]  NUM_IF_RESET = 5'd1;

   // Top nibble of a multicast destination (224/4)
   localparam logic [3:0]  MCAST_NIBBLE = 4'hE;

   typedef enum logic [1:0] {
      CMD_ADD       = 2'd0,
      CMD_DELETE    = 2'd1,
      CMD_UNICAST   = 2'd2,
      CMD_MULTICAST = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      STS_OK          = 3'd0,
      STS_BAD_DEFAULT = 3'd1,
      STS_NO_IFACE    = 3'd2,
      STS_FULL        = 3'd3,
      STS_NOT_FOUND   = 3'd4,
      STS_NO_ROUTE    = 3'd5
   } sts_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_START,
      ST_SCAN,
      ST_SHIFT_START,
      ST_SHIFT,
      ST_RESULT
   } state_type;

   // One route as held in the table memory
   typedef struct packed {
      logic [31:0] dest;
      logic [31:0] mask;
      logic [31:0] gateway;
      logic [15:0] metric;
      logic [3:0]  iface;
      logic        is_mc;
   } entry_type;

endpackage

### rtl/lprt_ram.sv
module lprt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/longest_prefix_route_table.sv
// Channel   Dir  Handshake                Payload
// req_      in   req_valid / req_stall    command, addresses, metric, interface
// rsp_      out  rsp_valid / rsp_stall    status, matched route, last
// csr_      in   csr_valid / csr_ready    num_interfaces
//
// Delete and lookups walk the table memory one entry per cycle through its
// single read port while no multicast match waits on a stalled result; a
// delete that hits then copies each entry above the removed one down one place
// (the compaction copy). Multicast results leave as they are found.
// Synchronous active-high reset empties the table and sets num_interfaces to 1.
// A stalled result holds the scan while a further multicast match waits.
module longest_prefix_route_table import lprt_pkg::*; #(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_command,
   input  logic [31:0]          req_dest_addr,
   input  logic [31:0]          req_net_mask,
   input  logic [31:0]          req_gateway_addr,
   input  logic [15:0]          req_route_metric,
   input  logic [3:0]           req_iface_index,
   input  logic                 req_iface_any,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_status,
   output logic [31:0]          rsp_out_gateway,
   output logic [3:0]           rsp_out_iface,
   output logic [15:0]          rsp_out_metric,
   output logic [31:0]          rsp_out_mask,
   output logic                 rsp_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [NUM_IF_W-1:0]  csr_num_interfaces
);

   localparam int IDX_W   = $clog2(TABLE_DEPTH);
   localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
   localparam int ENTRY_W = $bits(entry_type);

   // Control state
   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [NUM_IF_W-1:0]   num_if_ff, num_if_in;
   logic [CNT_W-1:0]      eval_idx_ff, eval_idx_in;
   logic [CNT_W-1:0]      del_idx_ff, del_idx_in;
   logic                  uc_found_ff, uc_found_in;
   logic [IDX_W-1:0]      uc_idx_ff, uc_idx_in;
   logic                  mc_found_ff, mc_found_in;
   logic [IDX_W-1:0]      mc_idx_ff, mc_idx_in;
   logic                  hit_valid_ff, hit_valid_in;
   logic [MC_CNT_W-1:0]   mc_cnt_ff, mc_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Command fields and working payload
   cmd_type               cmd_ff, cmd_in;
   logic [31:0]           dest_ff, dest_in;
   logic [31:0]           mask_ff, mask_in;
   logic [31:0]           gw_ff, gw_in;
   logic [15:0]           met_ff, met_in;
   logic [3:0]            ifc_ff, ifc_in;
   logic                  any_ff, any_in;
   entry_type             hit_ff, hit_in;
   sts_type               status_ff, status_in;

   // Result register
   sts_type               rsp_status_ff, rsp_status_in;
   logic [31:0]           rsp_gw_ff, rsp_gw_in;
   logic [3:0]            rsp_iface_ff, rsp_iface_in;
   logic [15:0]           rsp_metric_ff, rsp_metric_in;
   logic [31:0]           rsp_mask_ff, rsp_mask_in;
   logic                  rsp_last_ff, rsp_last_in;

   // Memory ports
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   entry_type             wr_entry;
   logic [IDX_W-1:0]      rd_addr;
   logic [ENTRY_W-1:0]    rd_word;
   entry_type             rd_entry;

   // Helpers
   logic [CNT_W-1:0]      eval_next;
   logic [CNT_W-1:0]      eval_prev;
   logic [CNT_W-1:0]      del_next;
   logic                  out_free;
   logic                  out_load;
   logic                  out_has;
   logic                  out_last;
   sts_type               out_sts;
   logic                  addr_hit;
   logic                  del_hit;
   logic                  advance;
   logic                  bad_default;
   logic                  bad_iface;
   logic                  table_full;

   lprt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   assign rd_entry  = entry_type'(rd_word);
   assign eval_next = eval_idx_ff + CNT_W'(1);
   assign eval_prev = eval_idx_ff - CNT_W'(1);
   assign del_next  = del_idx_ff + CNT_W'(1);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Per-entry compares against the command held in registers
   assign addr_hit = ((dest_ff ^ rd_entry.dest) & rd_entry.mask) == 32'd0;
   assign del_hit  = (dest_ff == 32'd0 || dest_ff == rd_entry.dest) &&
                     (mask_ff == 32'd0 || mask_ff == rd_entry.mask) &&
                     (gw_ff == 32'd0 || gw_ff == rd_entry.gateway) &&
                     (met_ff == 16'd0 || met_ff == rd_entry.metric) &&
                     (any_ff || ifc_ff == rd_entry.iface);

   // Add checks on the incoming request
   assign bad_default = (req_dest_addr == 32'd0) != (req_net_mask == 32'd0);
   assign bad_iface   = {1'b0, req_iface_index} >= num_if_ff;
   assign table_full  = count_ff >= CNT_W'(TABLE_DEPTH);

   // Sequencer: next state, memory access and result loading
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      num_if_in    = num_if_ff;
      eval_idx_in  = eval_idx_ff;
      del_idx_in   = del_idx_ff;
      uc_found_in  = uc_found_ff;
      uc_idx_in    = uc_idx_ff;
      mc_found_in  = mc_found_ff;
      mc_idx_in    = mc_idx_ff;
      hit_valid_in = hit_valid_ff;
      hit_in       = hit_ff;
      mc_cnt_in    = mc_cnt_ff;
      status_in    = status_ff;
      cmd_in       = cmd_ff;
      dest_in      = dest_ff;
      mask_in      = mask_ff;
      gw_in        = gw_ff;
      met_in       = met_ff;
      ifc_in       = ifc_ff;
      any_in       = any_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[IDX_W-1:0];
      wr_entry     = rd_entry;
      rd_addr      = eval_idx_ff[IDX_W-1:0];
      out_load     = 1'b0;
      out_has      = 1'b0;
      out_last     = 1'b1;
      out_sts      = status_ff;
      advance      = 1'b0;

      if (csr_valid && csr_ready) begin
         num_if_in = csr_num_interfaces;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in       = cmd_type'(req_command);
               dest_in      = req_dest_addr;
               mask_in      = req_net_mask;
               gw_in        = req_gateway_addr;
               met_in       = req_route_metric;
               ifc_in       = req_iface_index;
               any_in       = req_iface_any;
               uc_found_in  = 1'b0;
               mc_found_in  = 1'b0;
               hit_valid_in = 1'b0;
               mc_cnt_in    = '0;
               if (cmd_type'(req_command) == CMD_ADD) begin
                  state_in = ST_RESULT;
                  if (bad_default) begin
                     status_in = STS_BAD_DEFAULT;
                  end else if (bad_iface) begin
                     status_in = STS_NO_IFACE;
                  end else if (table_full) begin
                     status_in = STS_FULL;
                  end else begin
                     status_in        = STS_OK;
                     wr_en            = 1'b1;
                     wr_entry.dest    = req_dest_addr;
                     wr_entry.mask    = req_net_mask;
                     wr_entry.gateway = req_gateway_addr;
                     wr_entry.metric  = req_route_metric;
                     wr_entry.iface   = req_iface_index;
                     wr_entry.is_mc   = req_dest_addr[31:28] == MCAST_NIBBLE;
                     count_in         = count_ff + CNT_W'(1);
                  end
               end else begin
                  state_in = ST_SCAN_START;
               end
            end
         end

         // Prime the read port with the first entry
         ST_SCAN_START: begin
            rd_addr     = '0;
            eval_idx_in = '0;
            state_in    = ST_SCAN;
         end

         // One entry compared per cycle, unless a multicast match must hold for a stalled result
         ST_SCAN: begin
            if (eval_idx_ff >= count_ff) begin
               state_in = ST_RESULT;
               if (cmd_ff == CMD_DELETE) begin
                  if (uc_found_ff) begin
                     del_idx_in = CNT_W'(uc_idx_ff);
                     state_in   = ST_SHIFT_START;
                  end else if (mc_found_ff) begin
                     del_idx_in = CNT_W'(mc_idx_ff);
                     state_in   = ST_SHIFT_START;
                  end else begin
                     status_in = STS_NOT_FOUND;
                  end
               end
            end else begin
               advance = 1'b1;
               case (cmd_ff)
                  CMD_DELETE: begin
                     if (del_hit && !rd_entry.is_mc && !uc_found_ff) begin
                        uc_found_in = 1'b1;
                        uc_idx_in   = eval_idx_ff[IDX_W-1:0];
                     end
                     if (del_hit && rd_entry.is_mc && !mc_found_ff) begin
                        mc_found_in = 1'b1;
                        mc_idx_in   = eval_idx_ff[IDX_W-1:0];
                     end
                  end
                  CMD_UNICAST: begin
                     if (!rd_entry.is_mc && addr_hit &&
                         (!hit_valid_ff || rd_entry.mask > hit_ff.mask)) begin
                        hit_valid_in = 1'b1;
                        hit_in       = rd_entry;
                     end
                  end
                  CMD_MULTICAST: begin
                     if (rd_entry.is_mc && addr_hit) begin
                        if (hit_valid_ff && !out_free) begin
                           // previous match still cannot leave: hold here
                           advance = 1'b0;
                        end else begin
                           if (hit_valid_ff) begin
                              out_load = 1'b1;
                              out_sts  = STS_OK;
                              out_has  = 1'b1;
                              out_last = 1'b0;
                           end
                           hit_valid_in = 1'b1;
                           hit_in       = rd_entry;
                           if (mc_cnt_ff == MC_CNT_W'(MAX_RESULTS - 1)) begin
                              state_in = ST_RESULT;
                           end else begin
                              mc_cnt_in = mc_cnt_ff + MC_CNT_W'(1);
                           end
                        end
                     end
                  end
                  default: begin
                  end
               endcase
               if (advance) begin
                  rd_addr     = eval_next[IDX_W-1:0];
                  eval_idx_in = eval_next;
               end
            end
         end

         // Compaction: read the entry above the removed one
         ST_SHIFT_START: begin
            rd_addr     = del_next[IDX_W-1:0];
            eval_idx_in = del_next;
            state_in    = ST_SHIFT;
         end

         // Copy each following entry down one place
         ST_SHIFT: begin
            if (eval_idx_ff < count_ff) begin
               wr_en       = 1'b1;
               wr_addr     = eval_prev[IDX_W-1:0];
               wr_entry    = rd_entry;
               rd_addr     = eval_next[IDX_W-1:0];
               eval_idx_in = eval_next;
            end else begin
               count_in  = count_ff - CNT_W'(1);
               status_in = STS_OK;
               state_in  = ST_RESULT;
            end
         end

         // Final result of the command
         ST_RESULT: begin
            if (out_free) begin
               out_load = 1'b1;
               out_last = 1'b1;
               if (cmd_ff == CMD_UNICAST || cmd_ff == CMD_MULTICAST) begin
                  out_has = hit_valid_ff;
                  out_sts = hit_valid_ff ? STS_OK : STS_NO_ROUTE;
               end else begin
                  out_sts = status_ff;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result register next value
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_gw_in     = rsp_gw_ff;
      rsp_iface_in  = rsp_iface_ff;
      rsp_metric_in = rsp_metric_ff;
      rsp_mask_in   = rsp_mask_ff;
      rsp_last_in   = rsp_last_ff;
      if (out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = out_sts;
         rsp_gw_in     = out_has ? hit_ff.gateway : 32'd0;
         rsp_iface_in  = out_has ? hit_ff.iface : 4'd0;
         rsp_metric_in = out_has ? hit_ff.metric : 16'd0;
         rsp_mask_in   = out_has ? hit_ff.mask : 32'd0;
         rsp_last_in   = out_last;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         num_if_ff    <= NUM_IF_RESET;
         uc_found_ff  <= 1'b0;
         mc_found_ff  <= 1'b0;
         hit_valid_ff <= 1'b0;
         mc_cnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         num_if_ff    <= num_if_in;
         uc_found_ff  <= uc_found_in;
         mc_found_ff  <= mc_found_in;
         hit_valid_ff <= hit_valid_in;
         mc_cnt_ff    <= mc_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      eval_idx_ff   <= eval_idx_in;
      del_idx_ff    <= del_idx_in;
      uc_idx_ff     <= uc_idx_in;
      mc_idx_ff     <= mc_idx_in;
      hit_ff        <= hit_in;
      status_ff     <= status_in;
      cmd_ff        <= cmd_in;
      dest_ff       <= dest_in;
      mask_ff       <= mask_in;
      gw_ff         <= gw_in;
      met_ff        <= met_in;
      ifc_ff        <= ifc_in;
      any_ff        <= any_in;
      rsp_status_ff <= rsp_status_in;
      rsp_gw_ff     <= rsp_gw_in;
      rsp_iface_ff  <= rsp_iface_in;
      rsp_metric_ff <= rsp_metric_in;
      rsp_mask_ff   <= rsp_mask_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_stall       = state_ff != ST_IDLE;
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_gateway = rsp_gw_ff;
   assign rsp_out_iface   = rsp_iface_ff;
   assign rsp_out_metric  = rsp_metric_ff;
   assign rsp_out_mask    = rsp_mask_ff;
   assign rsp_last        = rsp_last_ff;

`ifndef SYNTHESIS
   // Fill count stays within the table
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("route count beyond table depth");

   // A finished compaction removes exactly one route
   a_delete_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT && eval_idx_ff >= count_ff)
      |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("delete did not shrink the table by one");

   // A result is never loaded over one that is still stalled
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("result register overwritten while stalled");

   // A held multicast match has always been counted
   a_mc_counted: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && cmd_ff == CMD_MULTICAST && hit_valid_ff)
      |-> mc_cnt_ff != '0)
      else $error("multicast match held without being counted");
`endif

endmodule

### test/route_table_checker.sv
// Watches the request, result and register channels of the route table,
// keeps its own copy of the table and counts every disagreement.
module route_table_checker import lprt_pkg::*; #(
   parameter int DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [1:0]           req_command,
   input  logic [31:0]          req_dest_addr,
   input  logic [31:0]          req_net_mask,
   input  logic [31:0]          req_gateway_addr,
   input  logic [15:0]          req_route_metric,
   input  logic [3:0]           req_iface_index,
   input  logic                 req_iface_any,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [2:0]           rsp_status,
   input  logic [31:0]          rsp_out_gateway,
   input  logic [3:0]           rsp_out_iface,
   input  logic [15:0]          rsp_out_metric,
   input  logic [31:0]          rsp_out_mask,
   input  logic                 rsp_last,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [NUM_IF_W-1:0]  csr_num_interfaces,
   output int                   outstanding,
   output int                   mismatches
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      sts_type      status;
      logic [31:0]  gateway;
      logic [3:0]   iface;
      logic [15:0]  metric;
      logic [31:0]  mask;
      logic         last;
   } route_result_type;

   // Routes in insertion order; a removal closes the gap
   entry_type             routes[$];
   route_result_type      awaited_results[$];
   logic [NUM_IF_W-1:0]   iface_limit = NUM_IF_RESET;
   int                    fail_total  = 0;

   function automatic void await_result(sts_type sts, entry_type e, bit found, bit last);
      route_result_type r;
      r.status  = sts;
      r.gateway = found ? e.gateway : '0;
      r.iface   = found ? e.iface   : '0;
      r.metric  = found ? e.metric  : '0;
      r.mask    = found ? e.mask    : '0;
      r.last    = last;
      awaited_results.insert(awaited_results.size(), r);
   endfunction

   // Zero fields and iface_any act as wildcards
   function automatic bit delete_hits(entry_type e, logic [31:0] d, logic [31:0] m,
                                      logic [31:0] g, logic [15:0] met,
                                      logic [3:0] ifc, logic any);
      return (d == '0 || d == e.dest) && (m == '0 || m == e.mask) &&
             (g == '0 || g == e.gateway) && (met == '0 || met == e.metric) &&
             (any || ifc == e.iface);
   endfunction

   function automatic bit covers(entry_type e, logic [31:0] addr);
      return ((addr ^ e.dest) & e.mask) == '0;
   endfunction

   // Applies one request to the shadow table and queues the results it gives
   function automatic void route_table_update(cmd_type cmd, logic [31:0] d, logic [31:0] m,
                                              logic [31:0] g, logic [15:0] met,
                                              logic [3:0] ifc, logic any);
      entry_type      e;
      entry_type      none;
      int             best;
      int             hits;
      int             i;
      int             pass;
      bit             done;
      none = '0;
      case (cmd)
         CMD_ADD: begin
            if ((d == '0) != (m == '0)) begin
               await_result(STS_BAD_DEFAULT, none, 1'b0, 1'b1);
            end else if ({1'b0, ifc} >= iface_limit) begin
               await_result(STS_NO_IFACE, none, 1'b0, 1'b1);
            end else if (routes.size() >= DEPTH) begin
               await_result(STS_FULL, none, 1'b0, 1'b1);
            end else begin
               e.dest    = d;
               e.mask    = m;
               e.gateway = g;
               e.metric  = met;
               e.iface   = ifc;
               e.is_mc   = (d[31:28] == MCAST_NIBBLE);
               routes.insert(routes.size(), e);
               await_result(STS_OK, none, 1'b0, 1'b1);
            end
         end
         CMD_DELETE: begin
            // unicast routes are searched before multicast ones
            done = 1'b0;
            for (pass = 0; pass < 2 && !done; pass++) begin
               for (i = 0; i < routes.size() && !done; i++) begin
                  if (routes[i].is_mc == pass[0] &&
                      delete_hits(routes[i], d, m, g, met, ifc, any)) begin
                     routes.delete(i);
                     done = 1'b1;
                  end
               end
            end
            await_result(done ? STS_OK : STS_NOT_FOUND, none, 1'b0, 1'b1);
         end
         CMD_UNICAST: begin
            // largest mask value wins, earliest entry on a tie
            best = -1;
            for (i = 0; i < routes.size(); i++) begin
               if (!routes[i].is_mc && covers(routes[i], d) &&
                   (best < 0 || routes[i].mask > routes[best].mask))
                  best = i;
            end
            if (best >= 0)
               await_result(STS_OK, routes[best], 1'b1, 1'b1);
            else
               await_result(STS_NO_ROUTE, none, 1'b0, 1'b1);
         end
         default: begin
            hits = 0;
            for (i = 0; i < routes.size() && hits < MAX_RESULTS; i++) begin
               if (routes[i].is_mc && covers(routes[i], d)) begin
                  await_result(STS_OK, routes[i], 1'b1, 1'b0);
                  hits++;
               end
            end
            if (hits == 0)
               await_result(STS_NO_ROUTE, none, 1'b0, 1'b1);
            else
               awaited_results[awaited_results.size() - 1].last = 1'b1;
         end
      endcase
   endfunction

   function automatic int field_differs(string field, logic [31:0] want, logic [31:0] got);
      if (want === got)
         return 0;
      $error("rsp_%s: expected %0h, got %0h", field, want, got);
      return 1;
   endfunction

   // Results are compared before the request of the same edge is applied
   always @(posedge clock) begin : watch
      route_result_type want;
      if (reset) begin
         routes.delete();
         awaited_results.delete();
         iface_limit = NUM_IF_RESET;
      end else begin
         if (csr_valid && csr_ready)
            iface_limit = csr_num_interfaces;
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               $error("result transfer with nothing awaited, status %0d", rsp_status);
               fail_total++;
            end else begin
               want = awaited_results.pop_front();
               fail_total += field_differs("status", 32'(want.status), 32'(rsp_status)) +
                             field_differs("out_gateway", want.gateway, rsp_out_gateway) +
                             field_differs("out_iface", 32'(want.iface),
                                           32'(rsp_out_iface)) +
                             field_differs("out_metric", 32'(want.metric),
                                           32'(rsp_out_metric)) +
                             field_differs("out_mask", want.mask, rsp_out_mask) +
                             field_differs("last", 32'(want.last), 32'(rsp_last));
            end
         end
         if (req_valid && !req_stall)
            route_table_update(cmd_type'(req_command), req_dest_addr, req_net_mask,
                               req_gateway_addr, req_route_metric, req_iface_index,
                               req_iface_any);
      end
      outstanding <= awaited_results.size();
      mismatches  <= fail_total;
   end

endmodule

### test/tb_longest_prefix_route_table.sv
module tb_longest_prefix_route_table;
   timeunit 1ns;
   timeprecision 1ps;
   import lprt_pkg::*;

   localparam int DEPTH       = DEFAULT_TABLE_DEPTH;
   localparam int TOTAL_ITEMS = 360;

   typedef struct {
      logic [31:0]  dest;
      logic [31:0]  mask;
      logic [31:0]  gw;
      logic [15:0]  metric;
      logic [3:0]   iface;
   } route_rec_type;

   logic                 clock              = 1'b0;
   logic                 reset              = 1'b1;
   logic                 req_valid          = 1'b0;
   logic                 req_stall;
   logic [1:0]           req_command        = '0;
   logic [31:0]          req_dest_addr      = '0;
   logic [31:0]          req_net_mask       = '0;
   logic [31:0]          req_gateway_addr   = '0;
   logic [15:0]          req_route_metric   = '0;
   logic [3:0]           req_iface_index    = '0;
   logic                 req_iface_any      = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall          = 1'b0;
   logic [2:0]           rsp_status;
   logic [31:0]          rsp_out_gateway;
   logic [3:0]           rsp_out_iface;
   logic [15:0]          rsp_out_metric;
   logic [31:0]          rsp_out_mask;
   logic                 rsp_last;
   logic                 csr_valid          = 1'b0;
   logic                 csr_ready;
   logic [NUM_IF_W-1:0]  csr_num_interfaces = NUM_IF_RESET;

   int                   outstanding;
   int                   mismatches;
   int                   items_sent         = 0;
   int                   iface_cap          = NUM_IF_RESET;
   bit                   steady             = 1'b0;
   logic [31:0]          pool[8];
   route_rec_type        added_routes[$];

   always #4 clock = ~clock;

   longest_prefix_route_table u_dut (.*);

   route_table_checker u_checker (.*);

   // Result side back-pressure, switched off during the steady stretch
   always @(posedge clock)
      rsp_stall <= !steady && ($urandom_range(99) < 19);

   function automatic logic [31:0] prefix_mask(int len);
      return (len == 0) ? 32'h0 : ~32'h0 << (32 - len);
   endfunction

   task automatic send_request(cmd_type cmd, logic [31:0] dest, logic [31:0] mask,
                               logic [31:0] gw, logic [15:0] metric,
                               logic [3:0] iface, logic any);
      if (!steady && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_dest_addr    <= dest;
      req_net_mask     <= mask;
      req_gateway_addr <= gw;
      req_route_metric <= metric;
      req_iface_index  <= iface;
      req_iface_any    <= any;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // Hold the request side off until every result is in, then let a delete
   // compaction or a trailing scan finish
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (2 * DEPTH + 8) @(posedge clock);
   endtask

   task automatic write_iface_count(logic [NUM_IF_W-1:0] value);
      wait_idle();
      csr_valid          <= 1'b1;
      csr_num_interfaces <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      iface_cap = value;
   endtask

   // Random commands around the address pool: add_pct adds, del_pct deletes,
   // the rest lookups, unicast more often than multicast
   task automatic mixed_traffic(int count, int add_pct, int del_pct);
      route_rec_type  r;
      logic [31:0]    addr;
      logic           any;
      int             roll;
      int             k;
      int             n;
      for (n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         if (roll < add_pct) begin
            k = $urandom_range(7);
            if ($urandom_range(99) < 15)
               r.mask = $urandom();
            else
               r.mask = prefix_mask(4 * $urandom_range(8));
            r.dest = ($urandom_range(99) < 10) ? pool[k] : pool[k] & r.mask;
            // occasional half-specified default route
            case ($urandom_range(19))
               0:       r.dest = '0;
               1:       r.mask = '0;
               default: ;
            endcase
            r.gw     = $urandom();
            r.metric = 16'($urandom());
            if (iface_cap > 0 && $urandom_range(99) < 75)
               r.iface = 4'($urandom_range(((iface_cap > 16) ? 16 : iface_cap) - 1));
            else
               r.iface = 4'($urandom());
            added_routes.insert(added_routes.size(), r);
            if (added_routes.size() > 64)
               void'(added_routes.pop_front());
            send_request(CMD_ADD, r.dest, r.mask, r.gw, r.metric, r.iface, 1'($urandom()));
         end else if (roll < add_pct + del_pct) begin
            if (added_routes.size() > 0 && $urandom_range(99) < 75) begin
               r = added_routes[$urandom_range(added_routes.size() - 1)];
            end else begin
               r.dest   = $urandom();
               r.mask   = $urandom();
               r.gw     = $urandom();
               r.metric = 16'($urandom());
               r.iface  = 4'($urandom());
            end
            if ($urandom_range(3) == 0) r.dest   = '0;
            if ($urandom_range(3) == 0) r.mask   = '0;
            if ($urandom_range(3) == 0) r.gw     = '0;
            if ($urandom_range(3) == 0) r.metric = '0;
            any = ($urandom_range(99) < 30);
            send_request(CMD_DELETE, r.dest, r.mask, r.gw, r.metric, r.iface, any);
         end else begin
            if ($urandom_range(99) < 60) begin
               k = $urandom_range(7);
               addr = pool[k] ^ ($urandom() & ~prefix_mask(4 * $urandom_range(8)));
               if ($urandom_range(99) < 15) addr = $urandom();
               send_request(CMD_UNICAST, addr, $urandom(), $urandom(), 16'($urandom()),
                            4'($urandom()), 1'($urandom()));
            end else begin
               k = $urandom_range(4, 7);
               addr = pool[k] ^ ($urandom() & ~prefix_mask(4 * $urandom_range(8)));
               if ($urandom_range(99) < 15) addr = $urandom();
               send_request(CMD_MULTICAST, addr, $urandom(), $urandom(), 16'($urandom()),
                            4'($urandom()), 1'($urandom()));
            end
         end
      end
   endtask

   initial begin : stimulus
      int phase;
      int k;
      phase = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Default route and the add checks, with one interface configured
      send_request(CMD_ADD, 32'h0, 32'h0, 32'hC0A8_0001, 16'd1, 4'd0, 1'b0);
      send_request(CMD_ADD, 32'h0A00_0000, 32'h0, 32'h1, 16'd1, 4'd0, 1'b0);
      send_request(CMD_ADD, 32'h0, 32'hFF00_0000, 32'h1, 16'd1, 4'd0, 1'b0);
      send_request(CMD_ADD, 32'h0A00_0000, 32'hFF00_0000, 32'h2, 16'd2, 4'd1, 1'b0);
      send_request(CMD_ADD, 32'h0A00_0000, 32'hFF00_0000, 32'h0A00_0001, 16'd10, 4'd0, 1'b1);
      send_request(CMD_ADD, 32'h0A01_0000, 32'hFFFF_0000, 32'hFFFF_FFFF, 16'hFFFF, 4'd0, 1'b0);
      send_request(CMD_ADD, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_00FE, 16'd0, 4'd0, 1'b0);

      // Longest prefix, tie to the earliest, fall back to the default route
      send_request(CMD_UNICAST, 32'h0A01_0203, '0, '0, '0, '0, 1'b0);
      send_request(CMD_UNICAST, 32'h0B00_0000, '0, '0, '0, '0, 1'b0);
      send_request(CMD_UNICAST, 32'hFFFF_FFFF, '0, '0, '0, '0, 1'b0);

      // Multicast routes: several matches, one match, none
      send_request(CMD_ADD, 32'hE000_0000, 32'hF000_0000, 32'h0A00_00E0, 16'd5, 4'd0, 1'b0);
      send_request(CMD_ADD, 32'hEFFF_FFFF, 32'hFFFF_FFFF, 32'h0A00_00EF, 16'd6, 4'd0, 1'b0);
      send_request(CMD_MULTICAST, 32'hEFFF_FFFF, '0, '0, '0, '0, 1'b0);
      send_request(CMD_MULTICAST, 32'hE000_0001, '0, '0, '0, '0, 1'b0);
      send_request(CMD_MULTICAST, 32'h0A00_0000, '0, '0, '0, '0, 1'b0);
      send_request(CMD_UNICAST, 32'hE000_0001, '0, '0, '0, '0, 1'b0);

      // Deletes: all wildcards, no match, multicast after the unicast pass,
      // earliest of two equal routes
      send_request(CMD_DELETE, '0, '0, '0, '0, 4'hF, 1'b1);
      send_request(CMD_UNICAST, 32'h0B00_0000, '0, '0, '0, '0, 1'b0);
      send_request(CMD_DELETE, '0, '0, 32'h1234_5678, '0, 4'd0, 1'b1);
      send_request(CMD_DELETE, '0, 32'hF000_0000, '0, '0, 4'd0, 1'b1);
      send_request(CMD_DELETE, 32'h0A01_0000, 32'hFFFF_0000, '0, '0, 4'd0, 1'b0);
      send_request(CMD_UNICAST, 32'h0A01_0203, '0, '0, '0, '0, 1'b0);

      // No interfaces rejects every add; the widest count admits interface 15
      write_iface_count(5'd0);
      send_request(CMD_ADD, 32'h0A02_0000, 32'hFFFF_0000, 32'h1, 16'd1, 4'd0, 1'b0);
      write_iface_count(5'd31);
      send_request(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 4'hF, 1'b1);

      // Mixed traffic under changing interface counts; the second stretch
      // runs with no idling on either side
      while (items_sent < TOTAL_ITEMS - 150) begin
         write_iface_count(5'($urandom_range(1, 16)));
         for (k = 0; k < 8; k++)
            pool[k] = (k < 4) ? $urandom() : {MCAST_NIBBLE, 28'($urandom())};
         steady <= (phase == 1);
         mixed_traffic(30, 40, 20);
         phase++;
      end
      steady <= 1'b0;

      // Fill past capacity, then look up in the full table
      write_iface_count(5'd31);
      mixed_traffic(36, 100, 0);
      mixed_traffic(8, 0, 0);

      // Delete-heavy sweep with a single interface
      write_iface_count(5'd1);
      mixed_traffic(24, 10, 60);

      // Empty the table, fill it with covering multicast routes, then take
      // the full burst of results per lookup
      wait_idle();
      repeat (DEPTH + 2)
         send_request(CMD_DELETE, '0, '0, '0, '0, 4'($urandom()), 1'b1);
      write_iface_count(5'd16);
      repeat (DEPTH)
         send_request(CMD_ADD, {MCAST_NIBBLE, 28'($urandom())}, 32'hF000_0000, $urandom(),
                      16'($urandom()), 4'($urandom()), 1'($urandom()));
      repeat (4)
         send_request(CMD_MULTICAST, {MCAST_NIBBLE, 28'($urandom())}, '0, '0, '0, '0, 1'b0);
      repeat (2)
         send_request(CMD_UNICAST, $urandom(), '0, '0, '0, '0, 1'b0);

      // Zero interfaces again under random traffic
      write_iface_count(5'd0);
      mixed_traffic(10, 60, 10);

      wait_idle();
      if (mismatches == 0)
         $display("tb_longest_prefix_route_table: clean");
      else
         $display("tb_longest_prefix_route_table: errors");
      $finish;
   end

   initial begin
      #5ms;
      $display("tb_longest_prefix_route_table: errors");
      $finish;
   end

endmodule
